@@ design/orl_pkg.sv @@
// Shared types and codes for the ordered record list.
package orl_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Command opcodes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_REM_SEARCH,
        S_REM_SHIFT,
        S_DONE
    } t_state;

    // One stored record
    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        name;
        logic [63:0]        post;
    } t_entry;

    // One result item
    typedef struct packed {
        t_status     status;
        logic [6:0]  entry_count;
        logic [5:0]  entry_index;
    } t_result;

endpackage

@@ design/orl_in_if.sv @@
// Command channel interface: valid/ready plus one command item.
interface orl_in_if;
    logic               valid;
    logic               ready;
    orl_pkg::t_opcode   opcode;
    logic signed [31:0] record_key;
    logic [63:0]        name_word;
    logic [63:0]        post_word;
    logic [6:0]         slot_position;

    modport source (output valid, opcode, record_key, name_word, post_word, slot_position,
                    input ready);
    modport sink   (input valid, opcode, record_key, name_word, post_word, slot_position,
                    output ready);
endinterface

@@ design/orl_out_if.sv @@
// Result channel interface: valid/ready plus one result item.
interface orl_out_if;
    logic              valid;
    logic              ready;
    orl_pkg::t_status  status;
    logic [6:0]        entry_count;
    logic [5:0]        entry_index;

    modport source (output valid, status, entry_count, entry_index, input ready);
    modport sink   (input valid, status, entry_count, entry_index, output ready);
endinterface

@@ design/orl_ram.sv @@
// Record store: one write port, one read port, registered read data.
module orl_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  orl_pkg::t_entry   i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output orl_pkg::t_entry   o_rdata
);
    import orl_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ordered_record_list.sv @@
// Ordered record list: insert at position, remove first record by key.
//
// Usage:
//   i_cmd carries one command item (opcode, record_key, name_word,
//   post_word, slot_position) under valid/ready; o_res returns exactly one
//   result item (status, entry_count, entry_index) per command.
//   Records live in one synchronous RAM of CAPACITY entries (registered
//   read data); the controller walks it one entry per cycle.
//   Insert at 1-based position s: S_INS_SHIFT moves each record at or
//   above s up by one, then S_INS_WRITE stores the new record.
//   Remove: S_REM_SEARCH scans from entry 0 to the first match (a miss
//   scans to the last entry), then S_REM_SHIFT moves the tail down.
//   Errors detected at accept (bad position, full, empty list) go
//   straight to S_DONE. One item in flight. A new command is taken as
//   soon as the controller is idle, even while the previous result still
//   sits in the output register.
//   If the receiver stalls, the finished result waits and the controller
//   holds until the output register frees up.
//   Reset (i_rst_n low, synchronous) empties the list; the RAM is not
//   cleared since only entries below the fill count are ever used.
//   Shifts read one entry ahead of the write, so no forwarding is needed.
module ordered_record_list #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    orl_in_if.sink    i_cmd,
    orl_out_if.source o_res
);
    import orl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW + 1 > 7) ? CW + 1 : 7;

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic [AW-1:0]   r_slot, n_slot;
    logic [AW-1:0]   r_hit, n_hit;
    t_status         r_status, n_status;
    logic            r_out_valid, n_out_valid;

    // payload registers
    logic signed [31:0] r_key;
    logic [63:0]        r_name;
    logic [63:0]        r_post;
    t_result            r_res, n_res;

    // RAM ports
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;
    logic [AW-1:0]   rd_addr;
    t_entry          rd_data;

    // helpers
    logic [PW-1:0]   pos_ext;
    logic [PW-1:0]   pos_m1;
    logic [PW-1:0]   fill_p1;
    logic [CW-1:0]   fill_m1;
    logic [CW-1:0]   ptr_m1;
    logic [CW-1:0]   ptr_m2;
    logic [CW-1:0]   ptr_p1;
    logic            at_last;
    logic            key_hit;
    logic            cmd_take;

    orl_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_take    = i_cmd.valid && i_cmd.ready;

    assign pos_ext = PW'(i_cmd.slot_position);
    assign pos_m1  = pos_ext - PW'(1);
    assign fill_p1 = PW'(r_fill) + PW'(1);
    assign fill_m1 = r_fill - CW'(1);
    assign ptr_m1  = r_ptr - CW'(1);
    assign ptr_m2  = r_ptr - CW'(2);
    assign ptr_p1  = r_ptr + CW'(1);
    assign at_last = (ptr_p1 == r_fill);
    assign key_hit = (rd_data.key == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_slot      <= '0;
            r_hit       <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            r_slot      <= n_slot;
            r_hit       <= n_hit;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_key  <= i_cmd.record_key;
            r_name <= i_cmd.name_word;
            r_post <= i_cmd.post_word;
        end
        r_res <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_slot      = r_slot;
        n_hit       = r_hit;
        n_status    = r_status;
        n_out_valid = r_out_valid && !o_res.ready;
        n_res       = r_res;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = rd_data;
        rd_addr     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_take) begin
                    n_hit = '0;
                    if (i_cmd.opcode == OP_INSERT) begin
                        priority if (pos_ext == '0 || pos_ext > fill_p1) begin
                            n_status = ST_BAD_POS;
                            n_state  = S_DONE;
                        end else if (r_fill == CW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_slot = pos_m1[AW-1:0];
                            if (PW'(r_fill) == pos_m1) begin
                                // append: nothing to move
                                n_state = S_INS_WRITE;
                            end else begin
                                rd_addr = fill_m1[AW-1:0];
                                n_ptr   = r_fill;
                                n_state = S_INS_SHIFT;
                            end
                        end
                    end else begin
                        if (r_fill == '0) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            rd_addr = '0;
                            n_ptr   = '0;
                            n_state = S_REM_SEARCH;
                        end
                    end
                end
            end

            S_INS_SHIFT: begin
                // entry r_ptr-1 arrives; move it up to r_ptr
                wr_en   = 1'b1;
                wr_addr = r_ptr[AW-1:0];
                wr_data = rd_data;
                if (ptr_m1 == CW'(r_slot)) begin
                    n_state = S_INS_WRITE;
                end else begin
                    rd_addr = ptr_m2[AW-1:0];
                    n_ptr   = ptr_m1;
                end
            end

            S_INS_WRITE: begin
                wr_en    = 1'b1;
                wr_addr  = r_slot;
                wr_data  = '{key: r_key, name: r_name, post: r_post};
                n_fill   = r_fill + CW'(1);
                n_status = ST_OK;
                n_hit    = r_slot;
                n_state  = S_DONE;
            end

            S_REM_SEARCH: begin
                if (key_hit) begin
                    n_hit = r_ptr[AW-1:0];
                    if (at_last) begin
                        n_fill   = fill_m1;
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else begin
                        rd_addr = ptr_p1[AW-1:0];
                        n_ptr   = ptr_p1;
                        n_state = S_REM_SHIFT;
                    end
                end else if (at_last) begin
                    n_hit    = '0;
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    rd_addr = ptr_p1[AW-1:0];
                    n_ptr   = ptr_p1;
                end
            end

            S_REM_SHIFT: begin
                // entry r_ptr arrives; move it down to r_ptr-1
                wr_en   = 1'b1;
                wr_addr = ptr_m1[AW-1:0];
                wr_data = rd_data;
                if (at_last) begin
                    n_fill   = fill_m1;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    rd_addr = ptr_p1[AW-1:0];
                    n_ptr   = ptr_p1;
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_res       = '{status: r_status,
                                    entry_count: 7'(r_fill),
                                    entry_index: 6'(r_hit)};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_res.status;
    assign o_res.entry_count = r_res.entry_count;
    assign o_res.entry_index = r_res.entry_index;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_fill_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |=> $stable(r_fill))
        else $error("fill count moved outside an operation");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state != S_IDLE && r_state != S_DONE))
        else $error("RAM written while idle");

    a_err_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.status != ST_OK) |-> (r_res.entry_index == '0))
        else $error("error result with non-zero index");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_WRITE) |=> (r_fill == $past(r_fill) + CW'(1)))
        else $error("insert did not grow the list by one");
`endif

endmodule
